FILE: hdl/radiative_edge_sucv_assembly_top_defines.svh
// Assertion macros shared by the edge assembly design.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef RADIATIVE_EDGE_SUCV_ASSEMBLY_TOP_DEFINES_SVH
`define RADIATIVE_EDGE_SUCV_ASSEMBLY_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RESA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edge assembly assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RESA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edge assembly assertion failed");

`endif

FILE: hdl/resa_pkg.sv
package resa_pkg;

	// Fixed point format: Q15.16 in 32 bits.
	localparam int FRAC_BITS = 16;
	localparam int MAX_DIMS = 3;

	// Iterative units produce one result bit per stage.
	localparam int ITER = 32;
	localparam int UNIT_LAT = ITER + 1;

	// 1/(8*pi) scaled by 2^32.
	localparam logic signed [31:0] INV8PI_Q32 = 32'sd170891319;

	localparam logic [1:0] REG_ORD_X = 2'd0;
	localparam logic [1:0] REG_ORD_Y = 2'd1;
	localparam logic [1:0] REG_ORD_Z = 2'd2;
	localparam logic [1:0] REG_DIMS  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
		sx64 = {{32{x[31]}}, x};
	endfunction

	function automatic logic signed [63:0] smul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		smul = sx64(a) * sx64(b);
	endfunction

	function automatic logic ovf32(input logic signed [63:0] x);
		ovf32 = !((&x[63:31]) || !(|x[63:31]));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (ovf32(x)) begin
			sat32 = x[63] ? Q_MIN : Q_MAX;
		end else begin
			sat32 = x[31:0];
		end
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		abs32 = x[31] ? 32'(-x) : x;
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] x);
		abs64 = x[63] ? 64'(-x) : x;
	endfunction

endpackage

FILE: hdl/resa_isqrt.sv
module resa_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	typedef struct packed {
		logic [63:0] v;
		logic [31:0] r;
		logic [34:0] rem;
	} sq_stage_t;

	sq_stage_t st [0:resa_pkg::ITER];

	always_ff @(posedge clk) begin
		if (en) begin
			st[0] <= '{v: radicand, r: '0, rem: '0};
		end
	end

	// One root bit per stage, two radicand bits shifted in each time.
	for (genvar k = 0; k < resa_pkg::ITER; k++) begin : g_step
		logic [34:0] rem_sh;
		logic [34:0] trial;
		logic        ge;

		assign rem_sh = {st[k].rem[32:0], st[k].v[63:62]};
		assign trial  = {1'b0, st[k].r, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				st[k+1].v   <= {st[k].v[61:0], 2'b00};
				st[k+1].r   <= {st[k].r[30:0], ge};
				st[k+1].rem <= ge ? rem_sh - trial : rem_sh;
			end
		end
	end

	assign root = st[resa_pkg::ITER].r;

endmodule

FILE: hdl/resa_div.sv
module resa_div (
	input  logic               clk,
	input  logic               en,
	input  logic        [63:0] num,
	input  logic        [31:0] den,
	input  logic               neg,
	output logic signed [31:0] quo,
	output logic               ovf
);

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] low;
		logic [31:0] q;
		logic [31:0] den;
		logic        neg;
		logic        big;
	} dv_stage_t;

	dv_stage_t st [0:resa_pkg::ITER];

	// A quotient of 2^32 or more is flagged up front; the rest fits in 32 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			st[0] <= '{rem: num[63:32], low: num[31:0], q: '0, den: den, neg: neg,
				big: num[63:32] >= den};
		end
	end

	for (genvar k = 0; k < resa_pkg::ITER; k++) begin : g_step
		logic [32:0] trial;
		logic        ge;

		assign trial = {st[k].rem, st[k].low[31]};
		assign ge    = trial >= {1'b0, st[k].den};

		always_ff @(posedge clk) begin
			if (en) begin
				st[k+1].rem <= ge ? 32'(trial - {1'b0, st[k].den}) : trial[31:0];
				st[k+1].low <= {st[k].low[30:0], 1'b0};
				st[k+1].q   <= {st[k].q[30:0], ge};
				st[k+1].den <= st[k].den;
				st[k+1].neg <= st[k].neg;
				st[k+1].big <= st[k].big;
			end
		end
	end

	always_comb begin
		quo = st[resa_pkg::ITER].q;
		ovf = 1'b0;
		if (st[resa_pkg::ITER].big) begin
			quo = st[resa_pkg::ITER].neg ? resa_pkg::Q_MIN : resa_pkg::Q_MAX;
			ovf = 1'b1;
		end else if (st[resa_pkg::ITER].neg) begin
			if (st[resa_pkg::ITER].q > 32'h80000000) begin
				quo = resa_pkg::Q_MIN;
				ovf = 1'b1;
			end else begin
				quo = 32'(-st[resa_pkg::ITER].q);
			end
		end else if (st[resa_pkg::ITER].q[31]) begin
			quo = resa_pkg::Q_MAX;
			ovf = 1'b1;
		end
	end

endmodule

FILE: hdl/radiative_edge_sucv_assembly_top.sv
// Throughput: one item per cycle while the pipeline is not frozen; the six
// bit-per-stage units (two square roots, four divisions, each 33 stages deep)
// set the depth, not the rate.
// Backpressure freezes the whole pipeline only while a result waits at the output.
// Reset (arst_n low, asynchronous) clears all valid bits and sets the ordinate to
// zero and the dimension count to 3.
module radiative_edge_sucv_assembly_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] area_x,
	input  logic signed [31:0] area_y,
	input  logic signed [31:0] area_z,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] delta_z,
	input  logic        [63:0] intensity_pair,
	input  logic        [63:0] absorption_pair,
	input  logic        [63:0] scattering_pair,
	input  logic        [63:0] flux_pair,
	input  logic        [63:0] source_pair,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] lhs_left_left,
	output logic signed [31:0] lhs_left_right,
	output logic signed [31:0] lhs_right_left,
	output logic signed [31:0] lhs_right_right,
	output logic signed [31:0] rhs_left,
	output logic signed [31:0] rhs_right,
	output logic        [1:0]  status
);

	`include "radiative_edge_sucv_assembly_top_defines.svh"

	localparam int LAT = resa_pkg::UNIT_LAT;
	localparam int F   = resa_pkg::FRAC_BITS;

	// Values that ride along the back half of the pipeline.
	typedef struct packed {
		logic               v;
		logic               degen;
		logic               sat;
		logic signed [31:0] axdx;
		logic signed [31:0] sjaj;
		logic signed [31:0] ext;
		logic signed [31:0] p;
		logic signed [31:0] res;
		logic        [31:0] habs;
	} carry_t;

	typedef struct packed {
		logic               v;
		logic               sat;
		logic        [63:0] aa0;
		logic        [63:0] aa1;
		logic        [63:0] aa2;
		logic signed [63:0] ad0;
		logic signed [63:0] ad1;
		logic signed [63:0] ad2;
		logic signed [63:0] sa0;
		logic signed [63:0] sa1;
		logic signed [63:0] sa2;
		logic signed [63:0] scf0;
		logic signed [63:0] scf1;
		logic signed [31:0] e1;
		logic signed [31:0] e2;
		logic signed [31:0] iip;
		logic signed [31:0] ep;
		logic signed [31:0] di;
	} s1_t;

	typedef struct packed {
		logic               v;
		logic               sat;
		logic               degen;
		logic        [63:0] asq;
		logic signed [31:0] axdx;
		logic signed [31:0] sjaj;
		logic signed [31:0] ext;
		logic signed [31:0] iso;
		logic signed [31:0] iip;
		logic signed [31:0] ep;
		logic signed [31:0] di;
	} s2_t;

	typedef struct packed {
		logic               v;
		logic               sat;
		logic               degen;
		logic        [63:0] asq;
		logic signed [31:0] axdx;
		logic signed [31:0] sjaj;
		logic signed [31:0] ext;
		logic signed [31:0] ep;
		logic signed [63:0] mui_p;
		logic signed [63:0] iso_p;
		logic signed [63:0] p_p;
		logic signed [63:0] t_p;
	} s3_t;

	typedef struct packed {
		carry_t             c;
		logic signed [31:0] ep;
		logic signed [31:0] mui;
		logic signed [31:0] iso;
	} side_a_t;

	typedef struct packed {
		carry_t             c;
		logic signed [32:0] sucv;
		logic signed [31:0] m;
	} side_d_t;

	// Configuration registers.
	logic signed [31:0] ord_x_q;
	logic signed [31:0] ord_y_q;
	logic signed [31:0] ord_z_q;
	logic        [1:0]  dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_x_q <= '0;
			ord_y_q <= '0;
			ord_z_q <= '0;
			dims_q  <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				resa_pkg::REG_ORD_X: ord_x_q <= cfg_data;
				resa_pkg::REG_ORD_Y: ord_y_q <= cfg_data;
				resa_pkg::REG_ORD_Z: ord_z_q <= cfg_data;
				resa_pkg::REG_DIMS:  dims_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as one; it halts only when the output register is
	// full and the receiver stalls it.
	logic pipe_en;

	assign pipe_en  = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	// Stage 1: products and pair sums straight from the input item.
	logic               dims3;
	logic signed [31:0] az_m, dz_m, sz_m;
	logic signed [31:0] i_l, i_r, ab_l, ab_r, sc_l, sc_r, f_l, f_r, q_l, q_r;
	logic signed [63:0] e1_sum, e2_sum, di_sum;

	assign dims3 = (dims_q != 2'd2) && (resa_pkg::MAX_DIMS >= 3);
	assign az_m  = dims3 ? area_z : '0;
	assign dz_m  = dims3 ? delta_z : '0;
	assign sz_m  = dims3 ? ord_z_q : '0;

	assign i_l  = intensity_pair[31:0];
	assign i_r  = intensity_pair[63:32];
	assign ab_l = absorption_pair[31:0];
	assign ab_r = absorption_pair[63:32];
	assign sc_l = scattering_pair[31:0];
	assign sc_r = scattering_pair[63:32];
	assign f_l  = flux_pair[31:0];
	assign f_r  = flux_pair[63:32];
	assign q_l  = source_pair[31:0];
	assign q_r  = source_pair[63:32];

	assign e1_sum = resa_pkg::sx64(ab_l) + resa_pkg::sx64(sc_l);
	assign e2_sum = resa_pkg::sx64(ab_r) + resa_pkg::sx64(sc_r);
	assign di_sum = resa_pkg::sx64(i_r) - resa_pkg::sx64(i_l);

	s1_t s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (pipe_en) begin
			s1.v    <= in_valid;
			s1.aa0  <= resa_pkg::smul(area_x, area_x);
			s1.aa1  <= resa_pkg::smul(area_y, area_y);
			s1.aa2  <= resa_pkg::smul(az_m, az_m);
			s1.ad0  <= resa_pkg::smul(area_x, delta_x);
			s1.ad1  <= resa_pkg::smul(area_y, delta_y);
			s1.ad2  <= resa_pkg::smul(az_m, dz_m);
			s1.sa0  <= resa_pkg::smul(ord_x_q, area_x);
			s1.sa1  <= resa_pkg::smul(ord_y_q, area_y);
			s1.sa2  <= resa_pkg::smul(sz_m, az_m);
			s1.scf0 <= resa_pkg::smul(sc_l, f_l);
			s1.scf1 <= resa_pkg::smul(sc_r, f_r);
			s1.e1   <= resa_pkg::sat32(e1_sum);
			s1.e2   <= resa_pkg::sat32(e2_sum);
			s1.iip  <= 32'((resa_pkg::sx64(i_l) + resa_pkg::sx64(i_r)) >>> 1);
			s1.ep   <= 32'((resa_pkg::sx64(q_l) + resa_pkg::sx64(q_r)) >>> 1);
			s1.di   <= resa_pkg::sat32(di_sum);
			s1.sat  <= resa_pkg::ovf32(e1_sum) | resa_pkg::ovf32(e2_sum) |
				resa_pkg::ovf32(di_sum);
		end
	end

	// Stage 2: dot products, squared area magnitude, mean extinction.
	logic        [63:0] asq_sum;
	logic signed [63:0] ax_sum, sj_sum, iso_sum;

	assign asq_sum = s1.aa0 + s1.aa1 + s1.aa2;
	assign ax_sum  = (s1.ad0 >>> F) + (s1.ad1 >>> F) + (s1.ad2 >>> F);
	assign sj_sum  = (s1.sa0 >>> F) + (s1.sa1 >>> F) + (s1.sa2 >>> F);
	assign iso_sum = (s1.scf0 >>> F) + (s1.scf1 >>> F);

	s2_t s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else if (pipe_en) begin
			s2.v     <= s1.v;
			s2.asq   <= asq_sum;
			s2.axdx  <= resa_pkg::sat32(ax_sum);
			s2.sjaj  <= resa_pkg::sat32(sj_sum);
			s2.ext   <= 32'((resa_pkg::sx64(s1.e1) + resa_pkg::sx64(s1.e2)) >>> 1);
			s2.iso   <= resa_pkg::sat32(iso_sum);
			s2.iip   <= s1.iip;
			s2.ep    <= s1.ep;
			s2.di    <= s1.di;
			// A zero area vector or a zero a.dx makes the edge degenerate.
			s2.degen <= (asq_sum == '0) || (resa_pkg::sat32(ax_sum) == '0);
			s2.sat   <= s1.sat | resa_pkg::ovf32(ax_sum) | resa_pkg::ovf32(sj_sum) |
				resa_pkg::ovf32(iso_sum);
		end
	end

	// Stage 3: second round of products.
	s3_t s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3 <= '0;
		end else if (pipe_en) begin
			s3.v     <= s2.v;
			s3.sat   <= s2.sat;
			s3.degen <= s2.degen;
			s3.asq   <= s2.asq;
			s3.axdx  <= s2.axdx;
			s3.sjaj  <= s2.sjaj;
			s3.ext   <= s2.ext;
			s3.ep    <= s2.ep;
			s3.mui_p <= resa_pkg::smul(s2.ext, s2.iip);
			s3.iso_p <= resa_pkg::smul(s2.iso, resa_pkg::INV8PI_Q32);
			s3.p_p   <= resa_pkg::smul(s2.sjaj, s2.iip);
			s3.t_p   <= resa_pkg::smul(s2.di, s2.sjaj);
		end
	end

	// Stage 4: scale the products and set up the first divide and square root.
	side_a_t            s4_a;
	logic        [63:0] asq_s4;
	logic        [63:0] tnum_s4;
	logic               tneg_s4;
	logic        [31:0] axmag_s4;
	logic signed [63:0] mui_sh, p_sh;

	assign mui_sh = s3.mui_p >>> F;
	assign p_sh   = s3.p_p >>> F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_a     <= '0;
			asq_s4   <= '0;
			tnum_s4  <= '0;
			tneg_s4  <= 1'b0;
			axmag_s4 <= '0;
		end else if (pipe_en) begin
			s4_a.c.v     <= s3.v;
			s4_a.c.degen <= s3.degen;
			s4_a.c.sat   <= s3.sat | resa_pkg::ovf32(mui_sh) | resa_pkg::ovf32(p_sh);
			s4_a.c.axdx  <= s3.axdx;
			s4_a.c.sjaj  <= s3.sjaj;
			s4_a.c.ext   <= s3.ext;
			s4_a.c.p     <= resa_pkg::sat32(p_sh);
			s4_a.c.res   <= '0;
			s4_a.c.habs  <= '0;
			s4_a.ep      <= s3.ep;
			s4_a.mui     <= resa_pkg::sat32(mui_sh);
			s4_a.iso     <= 32'(s3.iso_p >>> 32);
			asq_s4       <= s3.asq;
			tnum_s4      <= resa_pkg::abs64(s3.t_p);
			tneg_s4      <= s3.t_p[63] ^ s3.axdx[31];
			axmag_s4     <= resa_pkg::abs32(s3.axdx);
		end
	end

	// Area magnitude and the transport term di*sjaj/axdx run side by side.
	logic        [31:0] amag;
	logic signed [31:0] t_quo;
	logic               t_ovf;

	resa_isqrt u_sqrt_area (
		.clk      (clk),
		.en       (pipe_en),
		.radicand (asq_s4),
		.root     (amag)
	);

	resa_div u_div_t (
		.clk (clk),
		.en  (pipe_en),
		.num (tnum_s4),
		.den (axmag_s4),
		.neg (tneg_s4),
		.quo (t_quo),
		.ovf (t_ovf)
	);

	side_a_t d1 [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				d1[k] <= '0;
			end
		end else if (pipe_en) begin
			d1[0] <= s4_a;
			for (int k = 1; k < LAT; k++) begin
				d1[k] <= d1[k-1];
			end
		end
	end

	// Stage 5: residual and setup of the edge length divide h = a.dx / |a|.
	logic signed [63:0] res_sum;
	carry_t             c5_n;
	carry_t             c5;
	logic        [31:0] amag_s5;
	logic        [63:0] hnum_s5;
	logic               hneg_s5;

	assign res_sum = resa_pkg::sx64(d1[LAT-1].mui) - resa_pkg::sx64(d1[LAT-1].ep) -
		resa_pkg::sx64(d1[LAT-1].iso) + resa_pkg::sx64(t_quo);

	always_comb begin
		c5_n     = d1[LAT-1].c;
		c5_n.res = resa_pkg::sat32(res_sum);
		c5_n.sat = d1[LAT-1].c.sat | resa_pkg::ovf32(res_sum) | t_ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c5      <= '0;
			amag_s5 <= '0;
			hnum_s5 <= '0;
			hneg_s5 <= 1'b0;
		end else if (pipe_en) begin
			c5      <= c5_n;
			amag_s5 <= amag;
			hnum_s5 <= {32'd0, resa_pkg::abs32(d1[LAT-1].c.axdx)} << F;
			hneg_s5 <= d1[LAT-1].c.axdx[31];
		end
	end

	logic signed [31:0] h_quo;
	logic               h_ovf;

	resa_div u_div_h (
		.clk (clk),
		.en  (pipe_en),
		.num (hnum_s5),
		.den (amag_s5),
		.neg (hneg_s5),
		.quo (h_quo),
		.ovf (h_ovf)
	);

	carry_t d2 [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				d2[k] <= '0;
			end
		end else if (pipe_en) begin
			d2[0] <= c5;
			for (int k = 1; k < LAT; k++) begin
				d2[k] <= d2[k-1];
			end
		end
	end

	// Stages 6 to 8: e*h, saturate, then (e*h)^2 + 4 for the tau root.
	carry_t             c6, c7, c8;
	carry_t             c6_n, c7_n;
	logic signed [63:0] ehp_s6;
	logic signed [31:0] eh_s7;
	logic        [63:0] sq_s8;

	always_comb begin
		c6_n      = d2[LAT-1];
		c6_n.habs = resa_pkg::abs32(h_quo);
		c6_n.sat  = d2[LAT-1].sat | h_ovf;
		c7_n      = c6;
		c7_n.sat  = c6.sat | resa_pkg::ovf32(ehp_s6 >>> F);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c6     <= '0;
			c7     <= '0;
			c8     <= '0;
			ehp_s6 <= '0;
			eh_s7  <= '0;
			sq_s8  <= '0;
		end else if (pipe_en) begin
			c6      <= c6_n;
			ehp_s6  <= resa_pkg::smul(d2[LAT-1].ext, h_quo);

			c7      <= c7_n;
			eh_s7   <= resa_pkg::sat32(ehp_s6 >>> F);

			c8      <= c7;
			sq_s8   <= resa_pkg::smul(eh_s7, eh_s7) + (64'd4 << (2 * F));
		end
	end

	logic [31:0] root;

	resa_isqrt u_sqrt_tau (
		.clk      (clk),
		.en       (pipe_en),
		.radicand (sq_s8),
		.root     (root)
	);

	carry_t d3 [0:LAT-1];
	carry_t d4 [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				d3[k] <= '0;
				d4[k] <= '0;
			end
		end else if (pipe_en) begin
			d3[0] <= c8;
			d4[0] <= d3[LAT-1];
			for (int k = 1; k < LAT; k++) begin
				d3[k] <= d3[k-1];
				d4[k] <= d4[k-1];
			end
		end
	end

	// tau = |h| / sqrt(4 + (e*h)^2); the root is at least two, so never zero.
	logic signed [31:0] tau_quo;
	logic               tau_ovf;

	resa_div u_div_tau (
		.clk (clk),
		.en  (pipe_en),
		.num ({32'd0, d3[LAT-1].habs} << F),
		.den (root),
		.neg (1'b0),
		.quo (tau_quo),
		.ovf (tau_ovf)
	);

	// Stages 10 to 13: tau*s.a, then the stabilization products.
	carry_t             c10, c11, c12;
	carry_t             c10_n, c11_n, c13_n;
	logic signed [63:0] tsp_s10;
	logic signed [31:0] ts_s11;
	logic signed [63:0] ddp_s12, sucvp_s12, mp_s12;
	side_d_t            s13;
	logic        [63:0] ddnum_s13;
	logic               ddneg_s13;
	logic        [31:0] axmag_s13;

	always_comb begin
		c10_n     = d4[LAT-1];
		c10_n.sat = d4[LAT-1].sat | tau_ovf;
		c11_n     = c10;
		c11_n.sat = c10.sat | resa_pkg::ovf32(tsp_s10 >>> F);
		c13_n     = c12;
		c13_n.sat = c12.sat | resa_pkg::ovf32(sucvp_s12 >>> F) |
			resa_pkg::ovf32(mp_s12 >>> F);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c10       <= '0;
			c11       <= '0;
			c12       <= '0;
			tsp_s10   <= '0;
			ts_s11    <= '0;
			ddp_s12   <= '0;
			sucvp_s12 <= '0;
			mp_s12    <= '0;
			s13       <= '0;
			ddnum_s13 <= '0;
			ddneg_s13 <= 1'b0;
			axmag_s13 <= '0;
		end else if (pipe_en) begin
			c10       <= c10_n;
			tsp_s10   <= resa_pkg::smul(tau_quo, d4[LAT-1].sjaj);

			c11       <= c11_n;
			ts_s11    <= resa_pkg::sat32(tsp_s10 >>> F);

			c12       <= c11;
			ddp_s12   <= resa_pkg::smul(ts_s11, c11.sjaj);
			sucvp_s12 <= resa_pkg::smul(ts_s11, c11.res);
			mp_s12    <= resa_pkg::smul(ts_s11, c11.ext);

			s13.c     <= c13_n;
			s13.sucv  <= 33'(-resa_pkg::sx64(resa_pkg::sat32(sucvp_s12 >>> F)));
			s13.m     <= 32'(-(resa_pkg::sat32(mp_s12 >>> F) >>> 1));
			ddnum_s13 <= resa_pkg::abs64(ddp_s12);
			ddneg_s13 <= ddp_s12[63] ^ c12.axdx[31];
			axmag_s13 <= resa_pkg::abs32(c12.axdx);
		end
	end

	logic signed [31:0] dd_quo;
	logic               dd_ovf;

	resa_div u_div_dd (
		.clk (clk),
		.en  (pipe_en),
		.num (ddnum_s13),
		.den (axmag_s13),
		.neg (ddneg_s13),
		.quo (dd_quo),
		.ovf (dd_ovf)
	);

	side_d_t d5 [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				d5[k] <= '0;
			end
		end else if (pipe_en) begin
			d5[0] <= s13;
			for (int k = 1; k < LAT; k++) begin
				d5[k] <= d5[k-1];
			end
		end
	end

	// Final stage: central plus stabilization terms into the output register.
	logic signed [63:0] c_w, dd_w, m_w, p_w, sucv_w;
	logic signed [63:0] l0, l1, l2, l3, r0, r1;
	logic               sat_all;

	assign c_w    = resa_pkg::sx64(d5[LAT-1].c.sjaj >>> 1);
	assign dd_w   = -resa_pkg::sx64(dd_quo);
	assign m_w    = resa_pkg::sx64(d5[LAT-1].m);
	assign p_w    = resa_pkg::sx64(d5[LAT-1].c.p);
	assign sucv_w = {{31{d5[LAT-1].sucv[32]}}, d5[LAT-1].sucv};

	assign l0 = c_w - dd_w + m_w;
	assign l1 = c_w + dd_w + m_w;
	assign l2 = -c_w + dd_w - m_w;
	assign l3 = -c_w - dd_w - m_w;
	assign r0 = -p_w - sucv_w;
	assign r1 = p_w + sucv_w;

	assign sat_all = d5[LAT-1].c.sat | dd_ovf | resa_pkg::ovf32(l0) |
		resa_pkg::ovf32(l1) | resa_pkg::ovf32(l2) | resa_pkg::ovf32(l3) |
		resa_pkg::ovf32(r0) | resa_pkg::ovf32(r1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid       <= 1'b0;
			lhs_left_left   <= '0;
			lhs_left_right  <= '0;
			lhs_right_left  <= '0;
			lhs_right_right <= '0;
			rhs_left        <= '0;
			rhs_right       <= '0;
			status          <= resa_pkg::ST_OK;
		end else if (pipe_en) begin
			out_valid <= d5[LAT-1].c.v;
			if (d5[LAT-1].c.degen) begin
				// Degenerate edges contribute nothing.
				lhs_left_left   <= '0;
				lhs_left_right  <= '0;
				lhs_right_left  <= '0;
				lhs_right_right <= '0;
				rhs_left        <= '0;
				rhs_right       <= '0;
				status          <= resa_pkg::ST_DEGEN;
			end else begin
				lhs_left_left   <= resa_pkg::sat32(l0);
				lhs_left_right  <= resa_pkg::sat32(l1);
				lhs_right_left  <= resa_pkg::sat32(l2);
				lhs_right_right <= resa_pkg::sat32(l3);
				rhs_left        <= resa_pkg::sat32(r0);
				rhs_right       <= resa_pkg::sat32(r1);
				status          <= sat_all ? resa_pkg::ST_SAT : resa_pkg::ST_OK;
			end
		end
	end

	`RESA_ASSERT_IMPL(a_degen_zero, out_valid && status == resa_pkg::ST_DEGEN, lhs_left_left == '0 && lhs_right_right == '0 && rhs_left == '0 && rhs_right == '0)
	`RESA_ASSERT_IMPL(a_ok_antisym, out_valid && status == resa_pkg::ST_OK, rhs_left == -rhs_right && lhs_right_left == -lhs_left_left)
	`RESA_ASSERT_NEXT(a_freeze_holds, !pipe_en, $stable(d5[LAT-1].c.v) && $stable(s1.v))

endmodule
